// ===== sv/ckc_pkg.sv =====
`timescale 1ns / 1ps

package ckc_pkg;

    // bit t set: code type t carries a key
    localparam logic [15:0] KEYED_TYPES = 16'hABFB;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [2:0] KEY_4 = 3'd4;
    localparam logic [2:0] KEY_5 = 3'd5;
    localparam logic [2:0] KEY_6 = 3'd6;
    localparam logic [2:0] KEY_7 = 3'd7;

    localparam int CODE_W = 48;

    typedef struct packed {
        logic              op;
        logic              auto_key;
        logic [2:0]        key_num;
        logic [CODE_W-1:0] code;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [CODE_W-1:0] code;
    } t_rsp;

endpackage

// ===== sv/ckc_stage.sv =====
`timescale 1ns / 1ps

// One register slot with valid/ready flow control; refills in the cycle it drains.
module ckc_stage #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic         n_valid;
    logic [W-1:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/ckc_core.sv =====
`timescale 1ns / 1ps

module ckc_core (
    input  ckc_pkg::t_req i_req,
    output ckc_pkg::t_rsp o_rsp
);
    import ckc_pkg::*;

    logic [7:0] b0, b1, b2, b3, b4, b5;
    logic [7:0] e1, e2, e3, e4, e5;
    logic [7:0] d1, d2, d3, d4, d5;
    logic [2:0] key;
    logic       ok;

    assign b0 = i_req.code[47:40];
    assign b1 = i_req.code[39:32];
    assign b2 = i_req.code[31:24];
    assign b3 = i_req.code[23:16];
    assign b4 = i_req.code[15:8];
    assign b5 = i_req.code[7:0];

    // auto key only applies when decrypting
    assign key = (i_req.op == OP_DECRYPT && i_req.auto_key) ? b0[2:0] : i_req.key_num;

    always_comb begin
        ok = KEYED_TYPES[b0[7:4]] && key[2];
        if (i_req.op == OP_ENCRYPT && (b0[2:0] != 3'd0 || i_req.auto_key)) begin
            ok = 1'b0;
        end
    end

    // encrypt: for keys 4 and 7 each byte uses the original bytes around it; keys 5 and 6 work byte by byte
    always_comb begin
        case (key)
            KEY_4: begin
                e5 = b5 ^ ((b4 & 8'h11) + (b3 ^ 8'h12) - 8'hDA + b2 + b1);
                e4 = b4 ^ ((b3 & 8'h11) + (b2 ^ 8'h12) - 8'h82 + b1);
                e3 = b3 ^ ((b2 & 8'h11) + (b1 ^ 8'h12) - 8'h40);
                e2 = b2 ^ ((b1 & 8'h11) + 8'hFA);
                e1 = b1 ^ 8'h25;
            end
            KEY_5: begin
                e1 = b1 - 8'h57;
                e2 = b2 - 8'h42;
                e3 = b3 - 8'h31;
                e4 = b4 - 8'h32;
                e5 = b5 - 8'h33;
            end
            KEY_6: begin
                e1 = (b1 ^ 8'd1) - 8'hAB;
                e2 = (b2 ^ 8'd2) - 8'hAB;
                e3 = (b3 ^ 8'd3) - 8'hAB;
                e4 = (b4 ^ 8'd4) - 8'hAB;
                e5 = (b5 ^ 8'd5) - 8'hAB;
            end
            default: begin
                e1 = b1 - ((b2 & 8'h73) - (b3 ^ 8'h90) + 8'hF5 + b4 + b5);
                e2 = b2 - ((b3 & 8'h73) - (b4 ^ 8'h90) + 8'h16 + b5);
                e3 = b3 - ((b4 & 8'h73) - (b5 ^ 8'h90) + 8'h5A);
                e4 = b4 - ((b5 & 8'h73) - 8'h35);
                e5 = b5 + 8'h35;
            end
        endcase
    end

    // decrypt: undoes the chains of keys 4 and 7, so each byte uses the already decoded ones
    always_comb begin
        case (key)
            KEY_4: begin
                d1 = b1 ^ 8'h25;
                d2 = b2 ^ ((d1 & 8'h11) + 8'hFA);
                d3 = b3 ^ ((d2 & 8'h11) + (d1 ^ 8'h12) - 8'h40);
                d4 = b4 ^ ((d3 & 8'h11) + (d2 ^ 8'h12) - 8'h82 + d1);
                d5 = b5 ^ ((d4 & 8'h11) + (d3 ^ 8'h12) - 8'hDA + d2 + d1);
            end
            KEY_5: begin
                d1 = b1 + 8'h57;
                d2 = b2 + 8'h42;
                d3 = b3 + 8'h31;
                d4 = b4 + 8'h32;
                d5 = b5 + 8'h33;
            end
            KEY_6: begin
                d1 = (b1 + 8'hAB) ^ 8'd1;
                d2 = (b2 + 8'hAB) ^ 8'd2;
                d3 = (b3 + 8'hAB) ^ 8'd3;
                d4 = (b4 + 8'hAB) ^ 8'd4;
                d5 = (b5 + 8'hAB) ^ 8'd5;
            end
            default: begin
                d5 = b5 - 8'h35;
                d4 = b4 + ((d5 & 8'h73) - 8'h35);
                d3 = b3 + ((d4 & 8'h73) - (d5 ^ 8'h90) + 8'h5A);
                d2 = b2 + ((d3 & 8'h73) - (d4 ^ 8'h90) + 8'h16 + d5);
                d1 = b1 + ((d2 & 8'h73) - (d3 ^ 8'h90) + 8'hF5 + d4 + d5);
            end
        endcase
    end

    always_comb begin
        if (!ok) begin
            o_rsp.status = 1'b1;
            o_rsp.code   = i_req.code;
        end else if (i_req.op == OP_ENCRYPT) begin
            o_rsp.status = 1'b0;
            o_rsp.code   = {b0 ^ {5'd0, key}, e1, e2, e3, e4, e5};
        end else begin
            o_rsp.status = 1'b0;
            o_rsp.code   = {b0 ^ {5'd0, key}, d1, d2, d3, d4, d5};
        end
    end

endmodule

// ===== sv/cheat_code_key_cipher.sv =====
`timescale 1ns / 1ps
// Path: s_ handshake, input register, cipher logic, result register, result valid on m_.
// Throughput: one word per cycle while m_tready is high; each register refills in
// the cycle it drains.
// Reset: synchronous, active low; clears both valid flags, payload registers keep data.
module cheat_code_key_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // code_in[47:0], key_num[50:48], auto_key[51], zero pad
    input  logic        s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // code_out[47:0]
    output logic        m_tuser   // status
);
    import ckc_pkg::*;

    t_req s_req;
    t_req w_req;
    logic w_req_valid;
    logic w_rsp_ready;
    t_rsp w_rsp;
    t_rsp m_rsp;

    assign s_req.op       = s_tuser;
    assign s_req.auto_key = s_tdata[51];
    assign s_req.key_num  = s_tdata[50:48];
    assign s_req.code     = s_tdata[47:0];

    ckc_stage #(.W($bits(t_req))) u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_req),
        .o_valid (w_req_valid),
        .i_ready (w_rsp_ready),
        .o_data  (w_req)
    );

    ckc_core u_core (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    ckc_stage #(.W($bits(t_rsp))) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_req_valid),
        .o_ready (w_rsp_ready),
        .i_data  (w_rsp),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_rsp)
    );

    assign m_tdata = m_rsp.code;
    assign m_tuser = m_rsp.status;

    // rejected code comes out untouched
    a_err_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_valid && w_rsp_ready && w_rsp.status) |=> (m_tdata == $past(w_req.code)))
        else $error("rejected code altered");

    // a good encrypt always leaves a key of 4..7 in byte 0
    a_enc_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_valid && !w_rsp.status && w_req.op == OP_ENCRYPT) |-> w_rsp.code[42])
        else $error("encrypted byte 0 lacks key");

    // input only stalls when both slots are full
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (w_req_valid && m_tvalid))
        else $error("input stalled with a free slot");

endmodule
